>>> rtl/core/tems_pkg.sv
`default_nettype none

package tems_pkg;

    localparam int STEP_W     = 16;
    localparam int KIND_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SHOWN_W    = 16;

    typedef enum logic [1:0] {
        ST_AT_START = 2'd0,
        ST_TO_END   = 2'd1,
        ST_AT_END   = 2'd2,
        ST_TO_START = 2'd3
    } travel_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_STARTED  = 3'd1,
        EV_REVERSED = 3'd2,
        EV_PAUSED   = 3'd3,
        EV_RESUMED  = 3'd4,
        EV_AT_START = 3'd5,
        EV_AT_END   = 3'd6,
        EV_RESET    = 3'd7
    } ev_t;

    localparam logic [KIND_W-1:0] KIND_TICK       = 4'd0;
    localparam logic [KIND_W-1:0] KIND_ACTIVATE   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_DEACTIVATE = 4'd2;
    localparam logic [KIND_W-1:0] KIND_SNAP       = 4'd3;
    localparam logic [KIND_W-1:0] KIND_GO_START   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_GO_END     = 4'd5;
    localparam logic [KIND_W-1:0] KIND_PAUSE      = 4'd6;
    localparam logic [KIND_W-1:0] KIND_RESUME     = 4'd7;
    localparam logic [KIND_W-1:0] KIND_RESET      = 4'd8;

    localparam logic [1:0] MODE_PINGPONG = 2'd0;
    localparam logic [1:0] MODE_LATCH    = 2'd1;
    localparam logic [1:0] MODE_FLIP     = 2'd2;

    localparam logic [1:0] RULE_CONTINUE = 2'd0;
    localparam logic [1:0] RULE_PAUSE    = 2'd1;
    localparam logic [1:0] RULE_REVERSE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MOVEMENT_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEACTIVATION_RULE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_STEP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETURN_STEP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATE_RETURN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_AT_END      = 3'd5;

    localparam logic [1:0]        RST_MOVEMENT_MODE     = MODE_PINGPONG;
    localparam logic [1:0]        RST_DEACTIVATION_RULE = RULE_CONTINUE;
    localparam logic [STEP_W-1:0] RST_FORWARD_STEP      = 16'd655;
    localparam logic [STEP_W-1:0] RST_RETURN_STEP       = 16'd655;
    localparam logic              RST_SEPARATE_RETURN   = 1'b0;
    localparam logic              RST_START_AT_END      = 1'b0;

    typedef struct packed {
        logic [1:0]        movement_mode;
        logic [1:0]        deactivation_rule;
        logic [STEP_W-1:0] forward_step;
        logic [STEP_W-1:0] return_step;
        logic              separate_return;
        logic              start_at_end;
    } cfg_t;

    typedef struct packed {
        ev_t                event_code;
        logic               accepted;
        logic               latch_set;
        logic               is_paused;
        travel_t            motion_state;
        logic [SHOWN_W-1:0] position;
    } res_t;

    localparam int M_TDATA_W = $bits(res_t);

endpackage

`default_nettype wire

>>> rtl/core/tems_cfg_regs.sv
`default_nettype none

module tems_cfg_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tems_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tems_pkg::CFG_DATA_W-1:0] cfg_data,
    output tems_pkg::cfg_t                       cfg
);
    import tems_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_MOVEMENT_MODE:     cfg_next.movement_mode     = cfg_data[1:0];
                CFG_DEACTIVATION_RULE: cfg_next.deactivation_rule = cfg_data[1:0];
                CFG_FORWARD_STEP:      cfg_next.forward_step      = cfg_data[STEP_W-1:0];
                CFG_RETURN_STEP:       cfg_next.return_step       = cfg_data[STEP_W-1:0];
                CFG_SEPARATE_RETURN:   cfg_next.separate_return   = cfg_data[0];
                CFG_START_AT_END:      cfg_next.start_at_end      = cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.movement_mode     <= RST_MOVEMENT_MODE;
            cfg_reg.deactivation_rule <= RST_DEACTIVATION_RULE;
            cfg_reg.forward_step      <= RST_FORWARD_STEP;
            cfg_reg.return_step       <= RST_RETURN_STEP;
            cfg_reg.separate_return   <= RST_SEPARATE_RETURN;
            cfg_reg.start_at_end      <= RST_START_AT_END;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tems_motion_core.sv
`default_nettype none

module tems_motion_core #(
    parameter int POSITION_BITS = 16,
    parameter int ELAPSED_BITS  = 8
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        advance,
    input  wire logic [tems_pkg::KIND_W-1:0] kind,
    input  wire logic [ELAPSED_BITS-1:0]     elapsed,
    input  wire logic                        level,
    input  wire tems_pkg::cfg_t              cfg,
    output tems_pkg::res_t                   result
);
    import tems_pkg::*;

    localparam int DELTA_W = STEP_W + ELAPSED_BITS;
    localparam int CMP_W   = (POSITION_BITS > DELTA_W) ? POSITION_BITS : DELTA_W;
    localparam logic [POSITION_BITS-1:0] POS_MAX  = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_ZERO = {POSITION_BITS{1'b0}};

    typedef struct packed {
        logic    acc;
        travel_t st;
        logic    pf;
        ev_t     ev;
    } req_t;

    travel_t                  state_reg;
    travel_t                  state_next;
    logic                     pause_reg;
    logic                     pause_next;
    logic                     latch_reg;
    logic                     latch_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;

    ev_t                      ev;
    logic                     acc;
    logic                     moving;
    logic                     flip_end;
    logic [STEP_W-1:0]        step;
    logic [DELTA_W-1:0]       delta;
    logic [CMP_W-1:0]         delta_ext;
    logic [POSITION_BITS-1:0] room;
    logic [SHOWN_W-1:0]       shown;

    function automatic req_t req_fn(input travel_t st, input logic pf, input logic to_end);
        req_t    r;
        travel_t at_st;
        travel_t go_st;
        at_st = to_end ? ST_AT_END : ST_AT_START;
        go_st = to_end ? ST_TO_END : ST_TO_START;
        r.acc = 1'b0;
        r.st  = st;
        r.pf  = pf;
        r.ev  = EV_NONE;
        if (st == at_st) begin
            r.acc = 1'b0;
        end else if (st == go_st) begin
            if (pf) begin
                r.acc = 1'b1;
                r.pf  = 1'b0;
                r.ev  = EV_RESUMED;
            end
        end else begin
            r.acc = 1'b1;
            r.st  = go_st;
            r.pf  = 1'b0;
            r.ev  = (st == ST_TO_END || st == ST_TO_START) ? EV_REVERSED : EV_STARTED;
        end
        return r;
    endfunction

    assign moving   = (state_reg == ST_TO_END) || (state_reg == ST_TO_START);
    assign flip_end = (state_reg == ST_AT_START) || (state_reg == ST_TO_START);
    assign step     = (state_reg == ST_TO_START && cfg.separate_return)
                      ? cfg.return_step : cfg.forward_step;
    assign delta    = DELTA_W'(step) * DELTA_W'(elapsed);
    assign delta_ext = CMP_W'(delta);
    assign room     = POS_MAX - pos_reg;

    always_comb begin
        req_t r;
        r          = req_fn(state_reg, pause_reg, 1'b1);
        state_next = state_reg;
        pause_next = pause_reg;
        latch_next = latch_reg;
        pos_next   = pos_reg;
        ev         = EV_NONE;
        acc        = 1'b0;
        case (kind)
            KIND_TICK: begin
                if (moving && !pause_reg && elapsed != '0) begin
                    acc = 1'b1;
                    if (state_reg == ST_TO_END) begin
                        if (CMP_W'(room) <= delta_ext) begin
                            pos_next = POS_MAX;
                        end else begin
                            pos_next = pos_reg + POSITION_BITS'(delta);
                        end
                        if (pos_next == POS_MAX) begin
                            state_next = ST_AT_END;
                            pause_next = 1'b0;
                            if (cfg.movement_mode == MODE_LATCH) begin
                                latch_next = 1'b1;
                            end
                            ev = EV_AT_END;
                        end
                    end else begin
                        if (CMP_W'(pos_reg) <= delta_ext) begin
                            pos_next = POS_ZERO;
                        end else begin
                            pos_next = pos_reg - POSITION_BITS'(delta);
                        end
                        if (pos_next == POS_ZERO) begin
                            state_next = ST_AT_START;
                            pause_next = 1'b0;
                            ev         = EV_AT_START;
                        end
                    end
                end
            end
            KIND_ACTIVATE: begin
                if (pause_reg) begin
                    if (moving) begin
                        acc        = 1'b1;
                        pause_next = 1'b0;
                        ev         = EV_RESUMED;
                    end
                end else begin
                    if (cfg.movement_mode == MODE_LATCH) begin
                        r = latch_reg ? '0 : req_fn(state_reg, pause_reg, 1'b1);
                    end else if (cfg.movement_mode == MODE_FLIP) begin
                        r = req_fn(state_reg, pause_reg, flip_end);
                    end else begin
                        r = req_fn(state_reg, pause_reg, 1'b1);
                    end
                    if (r.acc) begin
                        acc        = 1'b1;
                        state_next = r.st;
                        pause_next = r.pf;
                        ev         = r.ev;
                    end
                end
            end
            KIND_DEACTIVATE: begin
                if (moving) begin
                    if (cfg.deactivation_rule == RULE_PAUSE) begin
                        if (!pause_reg) begin
                            acc        = 1'b1;
                            pause_next = 1'b1;
                            ev         = EV_PAUSED;
                        end
                    end else if (cfg.deactivation_rule == RULE_REVERSE) begin
                        r = req_fn(state_reg, pause_reg, state_reg != ST_TO_END);
                        if (r.acc) begin
                            acc        = 1'b1;
                            state_next = r.st;
                            pause_next = r.pf;
                            ev         = r.ev;
                        end
                    end
                end else if (cfg.movement_mode != MODE_LATCH
                             && cfg.movement_mode != MODE_FLIP
                             && state_reg == ST_AT_END) begin
                    r = req_fn(state_reg, pause_reg, 1'b0);
                    if (r.acc) begin
                        acc        = 1'b1;
                        state_next = r.st;
                        pause_next = r.pf;
                        ev         = r.ev;
                    end
                end
            end
            KIND_SNAP: begin
                acc = 1'b1;
                if (cfg.movement_mode == MODE_LATCH) begin
                    if (level && !latch_reg) begin
                        pos_next   = POS_MAX;
                        state_next = ST_AT_END;
                        pause_next = 1'b0;
                        latch_next = 1'b1;
                    end
                end else if (cfg.movement_mode == MODE_FLIP) begin
                    if (level) begin
                        pos_next   = flip_end ? POS_MAX : POS_ZERO;
                        state_next = flip_end ? ST_AT_END : ST_AT_START;
                        pause_next = 1'b0;
                    end
                end else begin
                    pos_next   = level ? POS_MAX : POS_ZERO;
                    state_next = level ? ST_AT_END : ST_AT_START;
                    pause_next = 1'b0;
                end
            end
            KIND_GO_START, KIND_GO_END: begin
                r = req_fn(state_reg, pause_reg, kind == KIND_GO_END);
                if (r.acc) begin
                    acc        = 1'b1;
                    state_next = r.st;
                    pause_next = r.pf;
                    ev         = r.ev;
                end
            end
            KIND_PAUSE: begin
                if (moving && !pause_reg) begin
                    acc        = 1'b1;
                    pause_next = 1'b1;
                    ev         = EV_PAUSED;
                end
            end
            KIND_RESUME: begin
                if (moving && pause_reg) begin
                    acc        = 1'b1;
                    pause_next = 1'b0;
                    ev         = EV_RESUMED;
                end
            end
            KIND_RESET: begin
                acc        = 1'b1;
                ev         = EV_RESET;
                pause_next = 1'b0;
                pos_next   = cfg.start_at_end ? POS_MAX : POS_ZERO;
                state_next = cfg.start_at_end ? ST_AT_END : ST_AT_START;
                latch_next = (cfg.movement_mode == MODE_LATCH) && cfg.start_at_end;
            end
            default: begin
            end
        endcase
    end

    generate
        if (POSITION_BITS >= SHOWN_W) begin : g_shown_top
            assign shown = pos_next[POSITION_BITS-1 -: SHOWN_W];
        end else begin : g_shown_pad
            assign shown = {pos_next, {(SHOWN_W-POSITION_BITS){1'b0}}};
        end
    endgenerate

    always_comb begin
        result.event_code   = ev;
        result.accepted     = acc;
        result.latch_set    = latch_next;
        result.is_paused    = pause_next;
        result.motion_state = state_next;
        result.position     = shown;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RST_START_AT_END ? ST_AT_END : ST_AT_START;
            pause_reg <= 1'b0;
            latch_reg <= (RST_MOVEMENT_MODE == MODE_LATCH) && RST_START_AT_END;
            pos_reg   <= RST_START_AT_END ? POS_MAX : POS_ZERO;
        end else if (advance) begin
            state_reg <= state_next;
            pause_reg <= pause_next;
            latch_reg <= latch_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/two_endpoint_motion_sequencer_core.sv
// Input registers capture each transfer and the result register its result;
// one event per cycle unless m_tready stalls. Event logic, a step-by-elapsed
// multiply and a saturating add or subtract sit between those two registers.
// Reset: synchronous, active low; configuration returns to its defaults and
// the position rests at start, idle, unpaused, latch clear.
`default_nettype none

module two_endpoint_motion_sequencer_core #(
    parameter int POSITION_BITS = 16,
    parameter int ELAPSED_BITS  = 8
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // elapsed, level, zero pad
    input  wire logic [((ELAPSED_BITS+8)/8)*8-1:0]    s_tdata,
    // kind
    input  wire logic [tems_pkg::KIND_W-1:0]          s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // position, motion_state, is_paused, latch_set, accepted, event_code
    output logic [tems_pkg::M_TDATA_W-1:0]            m_tdata,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [tems_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [tems_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tems_pkg::*;

    cfg_t                    cfg;
    res_t                    result;

    logic                    in_valid_reg;
    logic                    in_valid_next;
    logic [KIND_W-1:0]       kind_reg;
    logic [ELAPSED_BITS-1:0] elapsed_reg;
    logic                    level_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    res_t                    out_res_reg;
    logic                    advance;
    logic                    in_xfer;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            kind_reg    <= s_tuser;
            elapsed_reg <= s_tdata[ELAPSED_BITS-1:0];
            level_reg   <= s_tdata[ELAPSED_BITS];
        end
        if (advance) begin
            out_res_reg <= result;
        end
    end

    tems_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tems_motion_core #(
        .POSITION_BITS (POSITION_BITS),
        .ELAPSED_BITS  (ELAPSED_BITS)
    ) u_motion_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .kind    (kind_reg),
        .elapsed (elapsed_reg),
        .level   (level_reg),
        .cfg     (cfg),
        .result  (result)
    );

endmodule

`default_nettype wire
